FILE: hw/rtl/gbt_pkg.sv
package gbt_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int NODE_W       = 6;
  localparam int VCOUNT_W     = 7;
  localparam int STATUS_W     = 2;

  typedef enum logic [1:0] {
    CMD_CLEAR    = 2'd0,
    CMD_ADD      = 2'd1,
    CMD_TRAVERSE = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_RANGE = 2'd1,
    STS_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    REG_MODE   = 1'b0,
    REG_VCOUNT = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RESULT,
    ST_ADD_RA,
    ST_ADD_RB,
    ST_ADD_CHK,
    ST_ADD_WA,
    ST_ADD_WB,
    ST_POP,
    ST_POP_WAIT,
    ST_DEG,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_FINISH
  } state_t;

  // One result handed from the sequencer to the output register.
  typedef struct packed {
    logic              vld;
    logic [NODE_W-1:0] vertex;
    status_t           status;
    logic              last;
  } emit_t;

endpackage

FILE: hw/rtl/gbt_emit.sv
module gbt_emit
  import gbt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  emit_t      emit,
  output logic       free,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast
);

  logic              vld_r;
  logic [NODE_W-1:0] vertex_r;
  status_t           status_r;
  logic              last_r;

  // The slot can be refilled in the same cycle in which its item leaves.
  assign free = !vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (free) begin
      vld_r <= emit.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (free && emit.vld) begin
      vertex_r <= emit.vertex;
      status_r <= emit.status;
      last_r   <= emit.last;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {status_r, vertex_r};
  assign out_tlast  = last_r;

endmodule

FILE: hw/rtl/graph_bfs_dfs_traversal.sv
// Graph traversal engine. Edges are loaded one item at a time into per-vertex
// adjacency lists (insertion order); a clear item empties the graph and a
// traverse item runs a breadth-first or depth-first search from a start vertex,
// selected by the traversal_mode register, producing one result item per
// visited vertex with tlast on the final one; clear and add items, and rejected
// traversals, return one status item instead. All work is done by one small
// sequencer that touches each memory at most once per step, and in_tready is
// low while it runs. During a traversal each adjacency entry scanned costs one
// neighbor-table read step plus one compare/push step; depth-first searches
// also pop and discard stale stack entries. Progress is set by the single read
// port of the neighbor table and work list. Result items stall the sequencer
// only when the output register is still occupied.
module graph_bfs_dfs_traversal
  import gbt_pkg::*;
#(
  parameter int MAX_DEGREE = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input item: [1:0] cmd, [7:2] first_node, [13:8] second_node.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,
  // Result item: [5:0] vertex, [7:6] status; last travels as out_tlast.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,
  output logic        out_tlast,
  input  logic        cfg_we,
  input  reg_idx_t    cfg_addr,
  input  logic [6:0]  cfg_wdata
);

  localparam int DW    = $clog2(MAX_DEGREE + 1);
  localparam int NBR_N = MAX_VERTICES * MAX_DEGREE;
  localparam int NA_W  = $clog2(NBR_N);
  localparam int WL_N  = NBR_N + 2;
  localparam int WA_W  = $clog2(WL_N);
  localparam int TW    = $clog2(WL_N + 1);

  // Configuration registers.
  logic                mode_r;
  logic [VCOUNT_W-1:0] vcount_r;
  logic [VCOUNT_W-1:0] n_act;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      vcount_r <= VCOUNT_W'(MAX_VERTICES);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MODE:   mode_r   <= cfg_wdata[0];
        REG_VCOUNT: vcount_r <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  assign n_act = (vcount_r > VCOUNT_W'(MAX_VERTICES)) ? VCOUNT_W'(MAX_VERTICES) : vcount_r;

  // Sequencer state and datapath registers.
  state_t                  st_r, st_nxt;
  logic [NODE_W-1:0]       a_r, a_nxt, b_r, b_nxt;
  status_t                 status_r, status_nxt;
  logic [DW-1:0]           deg_a_r, deg_a_nxt, deg_b_r, deg_b_nxt;
  logic [DW-1:0]           deg_r, deg_nxt, idx_r, idx_nxt;
  logic [NODE_W-1:0]       cur_r, cur_nxt, pend_r, pend_nxt;
  logic                    pend_vld_r, pend_vld_nxt;
  logic [TW-1:0]           head_r, head_nxt, tail_r, tail_nxt;
  logic [MAX_VERTICES-1:0] visited_r, visited_nxt;
  logic [MAX_VERTICES-1:0] deg_valid_r, deg_valid_nxt;

  // Memories, each with one write and one registered read port.
  logic [DW-1:0]     deg_mem [MAX_VERTICES];
  logic [NODE_W-1:0] nbr_mem [NBR_N];
  logic [NODE_W-1:0] wl_mem  [WL_N];
  logic [DW-1:0]     deg_q_r;
  logic              deg_qv_r;
  logic [NODE_W-1:0] nbr_q_r, wl_q_r;

  logic              deg_re, deg_we, nbr_re, nbr_we, wl_re, wl_we;
  logic [NODE_W-1:0] deg_raddr, deg_waddr;
  logic [DW-1:0]     deg_wdata, deg_eff, deg_b_use;
  logic [NA_W-1:0]   nbr_raddr, nbr_waddr;
  logic [NODE_W-1:0] nbr_wdata, wl_wdata;
  logic [WA_W-1:0]   wl_raddr, wl_waddr;

  emit_t             emit;
  logic              out_free;
  logic [NODE_W-1:0] in_first, in_second;
  cmd_t              in_cmd;

  assign in_cmd    = cmd_t'(in_tdata[1:0]);
  assign in_first  = in_tdata[7:2];
  assign in_second = in_tdata[13:8];
  assign in_tready = (st_r == ST_IDLE);

  // An entry whose list was never written since the last clear reads as empty.
  assign deg_eff   = deg_qv_r ? deg_q_r : '0;
  assign deg_b_use = (a_r == b_r) ? (deg_a_r + DW'(1)) : deg_b_r;

  always_ff @(posedge clk) begin
    if (deg_we) deg_mem[deg_waddr] <= deg_wdata;
    if (deg_re) begin
      deg_q_r  <= deg_mem[deg_raddr];
      deg_qv_r <= deg_valid_r[deg_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (nbr_we) nbr_mem[nbr_waddr] <= nbr_wdata;
    if (nbr_re) nbr_q_r <= nbr_mem[nbr_raddr];
  end

  always_ff @(posedge clk) begin
    if (wl_we) wl_mem[wl_waddr] <= wl_wdata;
    if (wl_re) wl_q_r <= wl_mem[wl_raddr];
  end

  always_comb begin
    st_nxt        = st_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    status_nxt    = status_r;
    deg_a_nxt     = deg_a_r;
    deg_b_nxt     = deg_b_r;
    deg_nxt       = deg_r;
    idx_nxt       = idx_r;
    cur_nxt       = cur_r;
    pend_nxt      = pend_r;
    pend_vld_nxt  = pend_vld_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    visited_nxt   = visited_r;
    deg_valid_nxt = deg_valid_r;
    deg_re        = 1'b0;
    deg_raddr     = a_r;
    deg_we        = 1'b0;
    deg_waddr     = a_r;
    deg_wdata     = deg_a_r + DW'(1);
    nbr_re        = 1'b0;
    nbr_raddr     = NA_W'(cur_r) * NA_W'(MAX_DEGREE) + NA_W'(idx_r);
    nbr_we        = 1'b0;
    nbr_waddr     = NA_W'(a_r) * NA_W'(MAX_DEGREE) + NA_W'(deg_a_r);
    nbr_wdata     = b_r;
    wl_re         = 1'b0;
    wl_raddr      = head_r[WA_W-1:0];
    wl_we         = 1'b0;
    wl_waddr      = tail_r[WA_W-1:0];
    wl_wdata      = nbr_q_r;
    emit          = '{vld: 1'b0, vertex: pend_r, status: STS_OK, last: 1'b0};

    unique case (st_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          a_nxt      = in_first;
          b_nxt      = in_second;
          status_nxt = STS_OK;
          unique case (in_cmd)
            CMD_CLEAR: begin
              deg_valid_nxt = '0;
              st_nxt        = ST_RESULT;
            end
            CMD_ADD: begin
              if ({1'b0, in_first} >= n_act || {1'b0, in_second} >= n_act) begin
                status_nxt = STS_RANGE;
                st_nxt     = ST_RESULT;
              end else begin
                st_nxt = ST_ADD_RA;
              end
            end
            CMD_TRAVERSE: begin
              if ({1'b0, in_first} >= n_act) begin
                status_nxt = STS_RANGE;
                st_nxt     = ST_RESULT;
              end else begin
                visited_nxt = '0;
                if (!mode_r) visited_nxt[in_first] = 1'b1;
                wl_we        = 1'b1;
                wl_waddr     = '0;
                wl_wdata     = in_first;
                head_nxt     = '0;
                tail_nxt     = TW'(1);
                pend_vld_nxt = 1'b0;
                st_nxt       = ST_POP;
              end
            end
            default: ;
          endcase
        end
      end

      ST_RESULT: begin
        if (out_free) begin
          emit   = '{vld: 1'b1, vertex: '0, status: status_r, last: 1'b1};
          st_nxt = ST_IDLE;
        end
      end

      ST_ADD_RA: begin
        deg_re    = 1'b1;
        deg_raddr = a_r;
        st_nxt    = ST_ADD_RB;
      end

      ST_ADD_RB: begin
        deg_a_nxt = deg_eff;
        deg_re    = 1'b1;
        deg_raddr = b_r;
        st_nxt    = ST_ADD_CHK;
      end

      ST_ADD_CHK: begin
        deg_b_nxt = deg_eff;
        st_nxt    = ST_ADD_WA;
        if (a_r == b_r) begin
          if ({1'b0, deg_a_r} + (DW+1)'(2) > (DW+1)'(MAX_DEGREE)) begin
            status_nxt = STS_FULL;
            st_nxt     = ST_RESULT;
          end
        end else if ({1'b0, deg_a_r} + (DW+1)'(1) > (DW+1)'(MAX_DEGREE) ||
                     {1'b0, deg_eff} + (DW+1)'(1) > (DW+1)'(MAX_DEGREE)) begin
          status_nxt = STS_FULL;
          st_nxt     = ST_RESULT;
        end
      end

      ST_ADD_WA: begin
        nbr_we               = 1'b1;
        deg_we               = 1'b1;
        deg_waddr            = a_r;
        deg_wdata            = deg_a_r + DW'(1);
        deg_valid_nxt[a_r]   = 1'b1;
        st_nxt               = ST_ADD_WB;
      end

      ST_ADD_WB: begin
        nbr_we             = 1'b1;
        nbr_waddr          = NA_W'(b_r) * NA_W'(MAX_DEGREE) + NA_W'(deg_b_use);
        nbr_wdata          = a_r;
        deg_we             = 1'b1;
        deg_waddr          = b_r;
        deg_wdata          = deg_b_use + DW'(1);
        deg_valid_nxt[b_r] = 1'b1;
        st_nxt             = ST_RESULT;
      end

      ST_POP: begin
        if (!mode_r) begin
          if (head_r >= tail_r) begin
            st_nxt = ST_FINISH;
          end else begin
            wl_re    = 1'b1;
            wl_raddr = head_r[WA_W-1:0];
            head_nxt = head_r + TW'(1);
            st_nxt   = ST_POP_WAIT;
          end
        end else begin
          if (tail_r == '0) begin
            st_nxt = ST_FINISH;
          end else begin
            wl_re    = 1'b1;
            wl_raddr = WA_W'(tail_r - TW'(1));
            tail_nxt = tail_r - TW'(1);
            st_nxt   = ST_POP_WAIT;
          end
        end
      end

      ST_POP_WAIT: begin
        if (mode_r && visited_r[wl_q_r]) begin
          st_nxt = ST_POP;
        end else if (!pend_vld_r || out_free) begin
          // The previous vertex is known not to be the final one now.
          emit.vld              = pend_vld_r;
          pend_nxt              = wl_q_r;
          pend_vld_nxt          = 1'b1;
          cur_nxt               = wl_q_r;
          visited_nxt[wl_q_r]   = 1'b1;
          deg_re                = 1'b1;
          deg_raddr             = wl_q_r;
          st_nxt                = ST_DEG;
        end
      end

      ST_DEG: begin
        deg_nxt = deg_eff;
        idx_nxt = '0;
        st_nxt  = ST_SCAN;
      end

      ST_SCAN: begin
        if (idx_r == deg_r) begin
          st_nxt = ST_POP;
        end else begin
          nbr_re  = 1'b1;
          idx_nxt = idx_r + DW'(1);
          st_nxt  = ST_SCAN_WAIT;
        end
      end

      ST_SCAN_WAIT: begin
        if ({1'b0, nbr_q_r} < n_act && !visited_r[nbr_q_r] && tail_r < TW'(WL_N)) begin
          wl_we    = 1'b1;
          tail_nxt = tail_r + TW'(1);
          if (!mode_r) visited_nxt[nbr_q_r] = 1'b1;
        end
        st_nxt = ST_SCAN;
      end

      ST_FINISH: begin
        if (out_free) begin
          emit   = '{vld: 1'b1, vertex: pend_r, status: STS_OK, last: 1'b1};
          st_nxt = ST_IDLE;
        end
      end

      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      pend_vld_r  <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      visited_r   <= '0;
      deg_valid_r <= '0;
    end else begin
      st_r        <= st_nxt;
      pend_vld_r  <= pend_vld_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      visited_r   <= visited_nxt;
      deg_valid_r <= deg_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    status_r <= status_nxt;
    deg_a_r  <= deg_a_nxt;
    deg_b_r  <= deg_b_nxt;
    deg_r    <= deg_nxt;
    idx_r    <= idx_nxt;
    cur_r    <= cur_nxt;
    pend_r   <= pend_nxt;
  end

  gbt_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .emit       (emit),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // The work list never runs past its storage.
  a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r <= TW'(WL_N))
    else $error("work list tail beyond depth");

  // A breadth-first search never reads past the tail.
  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (!mode_r && st_r != ST_IDLE) |-> head_r <= tail_r)
    else $error("work list head passed tail");

  // Every vertex that is being expanded has been marked visited.
  a_cur_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SCAN || st_r == ST_SCAN_WAIT) |-> visited_r[cur_r])
    else $error("expanding an unmarked vertex");

  // A result is only produced when the output slot can take it.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit.vld |-> out_free)
    else $error("result produced into a full output register");

endmodule
